>>> sv/rfv_pkg.sv
package rfv_pkg;

  localparam int unsigned HeaderBytes = 16;
  localparam logic [31:0] CrcPoly     = 32'h82F63B78;
  localparam logic [31:0] CrcInit     = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_BAD_MAGIC = 2'd2,
    STATUS_CRC_ERR   = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] version;
    logic [31:0] feature_flags;
    logic [31:0] stored_crc;
    logic [31:0] computed_crc;
    logic [31:0] body_bytes;
  } result_t;

  // reflected CRC-32C, one byte, LSB first
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> sv/rfv_in_if.sv
interface rfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/rfv_out_if.sv
interface rfv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] version;
  logic [31:0] feature_flags;
  logic [31:0] stored_crc;
  logic [31:0] computed_crc;
  logic [31:0] body_bytes;

  modport source (output valid, output status, output version, output feature_flags,
                  output stored_crc, output computed_crc, output body_bytes, input ready);
  modport sink   (input valid, input status, input version, input feature_flags,
                  input stored_crc, input computed_crc, input body_bytes, output ready);
endinterface

>>> sv/record_file_verifier_top.sv
// Record file verifier.
// byte_in carries the file one word (a byte plus a last flag) per handshake.
// Bytes 0-3 are checked against the magic register, bytes 4-15 are captured
// as the little-endian version, capability flags and stored CRC words, and
// every later byte is folded into a CRC-32C and counted.
// result_out carries one word per file, produced by the byte flagged last:
// status (ok / too short / bad magic / crc mismatch), header words, the
// computed CRC and the saturated body length.
// Throughput: one byte per cycle while byte_in.ready is high. The CRC
// update is an unrolled eight-bit step in the path from byte_in to the
// state and result registers. The result word of a last byte is
// registered into the output register, or into a one-word skid stage
// while the output register holds a result; byte_in.ready drops only
// while the skid stage holds a second result that result_out has not taken.
// The user writes magic (cfg_wr_en / cfg_wr_data) only while the block is idle; the block never checks.
// Reset (rst, synchronous) clears the file state, both result stages and
// the magic register; after each last byte the file state returns to its
// reset values, the magic register is kept.
module record_file_verifier_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  rfv_in_if.sink      byte_in,
  rfv_out_if.source   result_out,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import rfv_pkg::*;

  localparam logic [4:0] PosFull = 5'(HeaderBytes);
  localparam logic [4:0] PosLast = 5'(HeaderBytes - 1);

  // file state
  logic [31:0]            magic_word;
  logic [4:0]             byte_position, byte_position_next;
  logic                   magic_matched, magic_matched_next;
  logic [31:0]            version_word, version_word_next;
  logic [31:0]            flags_word, flags_word_next;
  logic [31:0]            header_crc_word, header_crc_word_next;
  logic [31:0]            crc_accum, crc_accum_next;
  logic [COUNT_WIDTH-1:0] body_count, body_count_next;

  // result stages
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  result_t new_result;

  logic       accept, res_fire, out_take;
  logic [7:0] b;
  logic [1:0] lane;
  logic [7:0] magic_lane;
  logic       complete;
  logic [31:0] crc_final;
  logic [63:0] cnt_wide;
  logic [31:0] cnt_clamped;

  assign byte_in.ready = !skid_valid;
  assign accept        = byte_in.valid && byte_in.ready;
  assign res_fire      = accept && byte_in.last_byte;
  assign out_take      = out_valid && result_out.ready;

  assign b          = byte_in.data_byte;
  assign lane       = byte_position[1:0];
  assign magic_lane = magic_word[{lane, 3'b000} +: 8];
  assign complete   = byte_position >= PosLast;

  // per-byte update of the file state
  always_comb begin
    magic_matched_next   = magic_matched;
    version_word_next    = version_word;
    flags_word_next      = flags_word;
    header_crc_word_next = header_crc_word;
    crc_accum_next       = crc_accum;
    body_count_next      = body_count;
    byte_position_next   = byte_position;
    priority if (byte_position < 5'd4) begin
      if (magic_lane != b) magic_matched_next = 1'b0;
    end else if (byte_position < 5'd8) begin
      version_word_next[{lane, 3'b000} +: 8] = b;
    end else if (byte_position < 5'd12) begin
      flags_word_next[{lane, 3'b000} +: 8] = b;
    end else if (byte_position < PosFull) begin
      header_crc_word_next[{lane, 3'b000} +: 8] = b;
    end else begin
      crc_accum_next = crc32c_byte(crc_accum, b);
      if (body_count != {COUNT_WIDTH{1'b1}}) body_count_next = body_count + COUNT_WIDTH'(1);
    end
    if (byte_position < PosFull) byte_position_next = byte_position + 5'd1;
  end

  // result word for a last byte
  assign crc_final   = ~crc_accum_next;
  assign cnt_wide    = 64'(body_count_next);
  assign cnt_clamped = (cnt_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : cnt_wide[31:0];

  always_comb begin
    if (!complete) begin
      new_result        = '0;
      new_result.status = STATUS_SHORT;
    end else begin
      new_result.version       = version_word_next;
      new_result.feature_flags = flags_word_next;
      new_result.stored_crc    = header_crc_word_next;
      new_result.computed_crc  = crc_final;
      new_result.body_bytes    = cnt_clamped;
      priority if (!magic_matched_next)          new_result.status = STATUS_BAD_MAGIC;
      else if (crc_final != header_crc_word_next) new_result.status = STATUS_CRC_ERR;
      else                                        new_result.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0;
    end else if (cfg_wr_en) begin
      magic_word <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_fire) begin
      byte_position   <= '0;
      magic_matched   <= 1'b1;
      version_word    <= '0;
      flags_word      <= '0;
      header_crc_word <= '0;
      crc_accum       <= CrcInit;
      body_count      <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      magic_matched   <= magic_matched_next;
      version_word    <= version_word_next;
      flags_word      <= flags_word_next;
      header_crc_word <= header_crc_word_next;
      crc_accum       <= crc_accum_next;
      body_count      <= body_count_next;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
        if (res_fire) out_data <= new_result;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
      skid_data  <= new_result;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.status        = out_data.status;
  assign result_out.version       = out_data.version;
  assign result_out.feature_flags = out_data.feature_flags;
  assign result_out.stored_crc    = out_data.stored_crc;
  assign result_out.computed_crc  = out_data.computed_crc;
  assign result_out.body_bytes    = out_data.body_bytes;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with output register empty");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> (out_valid && byte_position == 5'd0 && crc_accum == CrcInit))
    else $error("last byte did not produce a result and clear file state");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= PosFull)
    else $error("byte position ran past header");

  a_body_after_header: assert property (@(posedge clk) disable iff (rst)
    (byte_position != PosFull) |-> (body_count == '0 && crc_accum == CrcInit))
    else $error("body state moved before header complete");

endmodule

>>> test/record_file_verifier_top_tb.sv
`timescale 1ns / 1ps

module record_file_verifier_top_tb;
  import rfv_pkg::*;

  localparam int CycleLimit  = 400_000;
  localparam int RandomBytes = 400;

  // shapes of record file the stimulus can build
  typedef enum {
    REC_GOOD,
    REC_BAD_MAGIC,
    REC_BAD_CRC,
    REC_SHORT,
    REC_NOISE
  } rec_kind_e;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  rfv_in_if  byte_if ();
  rfv_out_if res_if ();

  record_file_verifier_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .result_out (res_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // file state tracked alongside the block
  logic [31:0] magic_reg;
  logic [4:0]  hdr_pos;
  bit          magic_ok;
  logic [31:0] ver_word;
  logic [31:0] flg_word;
  logic [31:0] hdr_crc;
  logic [31:0] body_crc;
  logic [31:0] body_len;   // COUNT_WIDTH is 32 here, so no clamp is needed

  result_t pending_results[$];

  bit steady;              // no idling on either side while set
  int bytes_sent;
  int results_checked;
  int magic_writes;
  int mismatches;
  int status_tally[4];
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // reflected CRC-32C, fed one data bit at a time, LSB first
  function automatic logic [31:0] crc32c_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0] ^ b[i]}});
    end
    return c;
  endfunction

  function automatic void clear_file();
    hdr_pos  = '0;
    magic_ok = 1'b1;
    ver_word = '0;
    flg_word = '0;
    hdr_crc  = '0;
    body_crc = CrcInit;
    body_len = '0;
  endfunction

  // advance the file state by one byte; returns 1 with the result on a last byte
  function automatic bit track_file_byte(input logic [7:0] b, input logic last,
                                         output result_t r);
    int  p;
    bit  full;
    p = hdr_pos;
    r = '0;
    if (p < 4) begin
      if (magic_reg[8*p +: 8] != b) magic_ok = 1'b0;
    end else if (p < 8) begin
      ver_word[8*(p-4) +: 8] = b;
    end else if (p < 12) begin
      flg_word[8*(p-8) +: 8] = b;
    end else if (p < HeaderBytes) begin
      hdr_crc[8*(p-12) +: 8] = b;
    end else begin
      body_crc = crc32c_fold(body_crc, b);
      if (body_len != '1) body_len++;
    end
    full = (p >= HeaderBytes - 1);
    if (p < HeaderBytes) hdr_pos = 5'(p + 1);
    if (!last) return 1'b0;

    if (!full) begin
      r.status = STATUS_SHORT;
    end else begin
      r.version       = ver_word;
      r.feature_flags = flg_word;
      r.stored_crc    = hdr_crc;
      r.computed_crc  = ~body_crc;
      r.body_bytes    = body_len;
      if (!magic_ok)                r.status = STATUS_BAD_MAGIC;
      else if (~body_crc != hdr_crc) r.status = STATUS_CRC_ERR;
      else                          r.status = STATUS_OK;
    end
    clear_file();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %08h, expected %08h", $time, what, got, want);
  endtask

  // one byte word onto byte_in, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (!steady && $urandom_range(99) < 20) begin
      byte_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= last;
    do @(posedge clk); while (!byte_if.ready);
    bytes_sent++;
    if (track_file_byte(b, last, r)) pending_results.insert(pending_results.size(), r);
  endtask

  // builds one file against the current magic and streams it
  task automatic send_record(input rec_kind_e kind, input int len,
                             input logic [31:0] ver, input logic [31:0] flg);
    logic [7:0]  rec[$];
    logic [7:0]  body[$];
    logic [31:0] crc;
    logic [31:0] stored;
    int          at;
    if (kind == REC_SHORT || kind == REC_NOISE) begin
      repeat (len) rec.insert(rec.size(), 8'($urandom));
    end else begin
      repeat (len) body.insert(body.size(), 8'($urandom));
      crc = CrcInit;
      foreach (body[i]) crc = crc32c_fold(crc, body[i]);
      stored = ~crc;
      // a single flipped bit is always caught by the CRC
      if (kind == REC_BAD_CRC || (kind == REC_BAD_MAGIC && $urandom_range(1) == 1))
        stored ^= 32'h1 << $urandom_range(31);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), magic_reg[8*i +: 8]);
      if (kind == REC_BAD_MAGIC) begin
        at = $urandom_range(3);
        rec[at] ^= 8'h01 << $urandom_range(7);
      end
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), ver[8*i +: 8]);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), flg[8*i +: 8]);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), stored[8*i +: 8]);
      rec = {rec, body};
    end
    foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    byte_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_magic(input logic [31:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    magic_reg = value;
    magic_writes++;
  endtask

  function automatic logic [31:0] pick_magic();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_body_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8);
    if (r < 95) return $urandom_range(40, 9);
    return $urandom_range(300, 100);
  endfunction

  // magic still at its reset value: a one-byte file and an empty-body file
  task automatic test_directed_edges();
    send_record(REC_SHORT, 1, '0, '0);
    send_record(REC_GOOD, 0, '1, '0);
  endtask

  // the magic register at its extremes and at a random value
  task automatic test_magic_settings();
    write_magic('1);
    send_record(REC_GOOD, 0, '0, '1);
    send_record(REC_BAD_MAGIC, 3, $urandom, $urandom);
    write_magic($urandom);
    send_record(REC_GOOD, 5, $urandom, $urandom);
    send_record(REC_BAD_CRC, 2, $urandom, $urandom);
    send_record(REC_SHORT, 15, '0, '0);
    write_magic('0);
    send_record(REC_GOOD, 1, $urandom, $urandom);
  endtask

  // back-to-back files with no gaps and no stalls
  task automatic test_steady_stream();
    steady = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 2) send_record(REC_BAD_CRC, $urandom_range(6), $urandom, $urandom);
      else            send_record(REC_GOOD, $urandom_range(6), $urandom, $urandom);
    end
    drain_results();
    steady = 1'b0;
  endtask

  // mostly well-formed files with random content, the rest damaged or noise
  task automatic test_random_files();
    int        start;
    int        files;
    int        pick;
    int        len;
    rec_kind_e kind;
    start = bytes_sent;
    files = 0;
    while (bytes_sent - start < RandomBytes) begin
      // periodic full drain doubles as the magic change point
      if (files % 4 == 3) write_magic(pick_magic());
      pick = $urandom_range(99);
      if (pick < 55)      kind = REC_GOOD;
      else if (pick < 70) kind = REC_BAD_MAGIC;
      else if (pick < 85) kind = REC_BAD_CRC;
      else if (pick < 93) kind = REC_SHORT;
      else                kind = REC_NOISE;
      if (kind == REC_SHORT)      len = $urandom_range(15, 1);
      else if (kind == REC_NOISE) len = $urandom_range(40, 1);
      else                        len = pick_body_len();
      send_record(kind, len, $urandom, $urandom);
      files++;
    end
  endtask

  // result side: random stalls, and every accepted word checked in order
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) res_if.ready <= 1'b0;
    else     res_if.ready <= steady || ($urandom_range(99) >= 20);
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(res_if.status), '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_tally[want.status]++;
        if (res_if.status !== want.status)
          report_mismatch("status", 32'(res_if.status), 32'(want.status));
        if (res_if.version !== want.version)
          report_mismatch("version", res_if.version, want.version);
        if (res_if.feature_flags !== want.feature_flags)
          report_mismatch("feature_flags", res_if.feature_flags,
                          want.feature_flags);
        if (res_if.stored_crc !== want.stored_crc)
          report_mismatch("stored_crc", res_if.stored_crc, want.stored_crc);
        if (res_if.computed_crc !== want.computed_crc)
          report_mismatch("computed_crc", res_if.computed_crc, want.computed_crc);
        if (res_if.body_bytes !== want.body_bytes)
          report_mismatch("body_bytes", res_if.body_bytes, want.body_bytes);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("** record_file_verifier_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    byte_if.valid       <= 1'b0;
    byte_if.data_byte   <= '0;
    byte_if.last_byte   <= 1'b0;
    magic_reg = '0;
    steady    = 1'b0;
    clear_file();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_magic_settings();
    test_steady_stream();
    test_random_files();
    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d bytes streamed, %0d results checked, %0d magic writes",
             bytes_sent, results_checked, magic_writes);
    $display("status seen: ok %0d, too short %0d, bad magic %0d, crc mismatch %0d",
             status_tally[STATUS_OK], status_tally[STATUS_SHORT],
             status_tally[STATUS_BAD_MAGIC], status_tally[STATUS_CRC_ERR]);
    if (mismatches == 0) begin
      $display("** record_file_verifier_top: PASSED **");
    end else begin
      $display("** record_file_verifier_top: FAILED **");
    end
    $finish;
  end

endmodule
